/* rtl/smrc4_pkg.sv */
// shared constants, types and command/status structs for the reduced rc4 block
// no dependencies; imported by every module of the block except smrc4_ram
package smrc4_pkg;

	localparam int TABLE_SIZE = 8;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int KEY_REGS   = 4;
	localparam int KEY_W      = 3;
	localparam int KIDX_W     = $clog2(KEY_REGS);
	localparam int DATA_W     = 8;
	localparam int KS_W       = 3;

	localparam logic KIND_REKEY = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	typedef enum logic [2:0] {
		RD_FIRST_GEN,
		RD_FIRST_KS,
		RD_SECOND_GEN,
		RD_SECOND_KS,
		RD_T
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_FIRST_GEN,
		WR_FIRST_KS,
		WR_SECOND
	} wr_sel_t;

	typedef struct packed {
		logic    clear;
		logic    load_data;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    gen_commit;
		logic    ks_advance;
	} cmd_t;

	typedef struct packed {
		logic n_last;
	} status_t;

endpackage

/* rtl/small_rc4_stream_cipher.sv */
// top level of the reduced rc4 stream cipher: controller plus datapath
// depends on smrc4_pkg, smrc4_ctrl, smrc4_datapath (and smrc4_ram below it)
//
// channel  | handshake                  | payload
// item     | item_valid / item_stall    | kind, data_in
// result   | result_valid / result_stall| data_out, key_stream
// config   | wr_en                      | wr_index, wr_data
//
// a data item keeps item_stall high through states G1 to G4 and its result
// is registered at the end of G4; a rekey runs K1 to K4 once per table entry;
// both sequences are set by the single read port of the table
// reset gives the identity table, zero counters and zero key words
// a full result register holds the last generator step until result_stall drops;
// the next item is accepted meanwhile and waits in state G4
module small_rc4_stream_cipher (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               kind,
	input  logic [smrc4_pkg::DATA_W-1:0]       data_in,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [smrc4_pkg::DATA_W-1:0]       data_out,
	output logic [smrc4_pkg::KS_W-1:0]         key_stream,
	input  logic                               wr_en,
	input  logic [smrc4_pkg::KIDX_W-1:0]       wr_index,
	input  logic [smrc4_pkg::KEY_W-1:0]        wr_data
);
	import smrc4_pkg::*;

	cmd_t    cmd;
	status_t status;

	smrc4_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.kind        (kind),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cmd         (cmd),
		.status      (status)
	);

	smrc4_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.data_in   (data_in),
		.data_out  (data_out),
		.key_stream(key_stream)
	);

`ifndef SYNTHESIS
	// table is only written while an item is in work
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> item_stall)
		else $error("table write while idle");

	// a new result only appears after a generator step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.gen_commit))
		else $error("result without generator step");

	// every accepted item makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("accepted item did not start work");

	// rekey start and data load never coincide
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear && cmd.load_data))
		else $error("rekey and data load together");
`endif

endmodule

/* rtl/smrc4_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module smrc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/smrc4_datapath.sv */
// datapath: permutation table, counters, key registers and result registers
// depends on smrc4_pkg and smrc4_ram
module smrc4_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  smrc4_pkg::cmd_t                    cmd,
	output smrc4_pkg::status_t                 status,
	input  logic                               wr_en,
	input  logic [smrc4_pkg::KIDX_W-1:0]       wr_index,
	input  logic [smrc4_pkg::KEY_W-1:0]        wr_data,
	input  logic [smrc4_pkg::DATA_W-1:0]       data_in,
	output logic [smrc4_pkg::DATA_W-1:0]       data_out,
	output logic [smrc4_pkg::KS_W-1:0]         key_stream
);
	import smrc4_pkg::*;

	logic [IDX_W-1:0]  i_q, j_q, n_q, kj_q;
	logic [IDX_W-1:0]  a_q, b_q, addr2_q, t_q, raddr_q;
	logic              rvld_q;
	logic [TABLE_SIZE-1:0] vld_q;
	logic [KEY_W-1:0]  key_q [KEY_REGS];
	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_out_q;
	logic [KS_W-1:0]   ks_out_q;

	logic [IDX_W-1:0]  i_next, raddr, waddr, wdata, rd_eff, key_n, ks_val;
	logic [IDX_W-1:0]  ram_rdata;

	assign i_next = i_q + IDX_W'(1);
	assign key_n  = IDX_W'(key_q[n_q[KIDX_W-1:0]]);
	// entries not written since the last rekey read as their own index
	assign rd_eff = rvld_q ? ram_rdata : raddr_q;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_FIRST_GEN:  raddr = i_next;
			RD_FIRST_KS:   raddr = n_q;
			RD_SECOND_GEN: raddr = j_q + rd_eff;
			RD_SECOND_KS:  raddr = kj_q + rd_eff + key_n;
			RD_T:          raddr = a_q + rd_eff;
			default:       raddr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_FIRST_GEN: begin
				waddr = i_next;
				wdata = rd_eff;
			end
			WR_FIRST_KS: begin
				waddr = n_q;
				wdata = rd_eff;
			end
			WR_SECOND: begin
				waddr = addr2_q;
				wdata = a_q;
			end
			default: begin
				waddr = '0;
				wdata = '0;
			end
		endcase
	end

	// keystream read overlapped the swap writes, forward the swapped values
	always_comb begin
		priority if (t_q == addr2_q) begin
			ks_val = a_q;
		end else if (t_q == i_next) begin
			ks_val = b_q;
		end else begin
			ks_val = rd_eff;
		end
	end

	smrc4_ram #(
		.WIDTH(IDX_W),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			n_q    <= '0;
			kj_q   <= '0;
			vld_q  <= '0;
			rvld_q <= 1'b0;
			for (int k = 0; k < KEY_REGS; k++) begin
				key_q[k] <= '0;
			end
		end else begin
			if (wr_en) begin
				key_q[wr_index] <= wr_data;
			end
			if (cmd.clear) begin
				i_q   <= '0;
				j_q   <= '0;
				n_q   <= '0;
				kj_q  <= '0;
				vld_q <= '0;
			end else begin
				if (cmd.wr_en) begin
					vld_q[waddr] <= 1'b1;
				end
				if (cmd.gen_commit) begin
					i_q <= i_next;
					j_q <= addr2_q;
				end
				if (cmd.ks_advance) begin
					n_q  <= n_q + IDX_W'(1);
					kj_q <= addr2_q;
				end
			end
			if (cmd.rd_en) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			data_q <= data_in;
		end
		if (cmd.rd_en) begin
			raddr_q <= raddr;
			if (cmd.rd_sel == RD_SECOND_GEN || cmd.rd_sel == RD_SECOND_KS) begin
				a_q     <= rd_eff;
				addr2_q <= raddr;
			end
			if (cmd.rd_sel == RD_T) begin
				b_q <= rd_eff;
				t_q <= raddr;
			end
		end
		if (cmd.gen_commit) begin
			data_out_q <= data_q ^ DATA_W'(ks_val);
			ks_out_q   <= KS_W'(ks_val);
		end
	end

	assign status.n_last = (n_q == IDX_W'(TABLE_SIZE - 1));
	assign data_out      = data_out_q;
	assign key_stream    = ks_out_q;

endmodule

/* rtl/smrc4_ctrl.sv */
// controller: sequences key schedule and generator steps, owns result valid
// depends on smrc4_pkg
module smrc4_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               kind,
	output logic               result_valid,
	input  logic               result_stall,
	output smrc4_pkg::cmd_t    cmd,
	input  smrc4_pkg::status_t status
);
	import smrc4_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G1, ST_G2, ST_G3, ST_G4,
		ST_K1, ST_K2, ST_K3, ST_K4
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   out_free;
	logic   result_set;

	assign out_free   = !result_valid_q || !result_stall;
	assign result_set = (state_q == ST_G4) && out_free;
	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.clear     = (kind == KIND_REKEY);
					cmd.load_data = (kind == KIND_DATA);
				end
			end
			ST_G1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_FIRST_GEN;
			end
			ST_G2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SECOND_GEN;
			end
			ST_G3: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_T;
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_FIRST_GEN;
			end
			ST_G4: begin
				// repeated while the result slot is full, the write is idempotent
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WR_SECOND;
				cmd.gen_commit = out_free;
			end
			ST_K1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_FIRST_KS;
			end
			ST_K2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SECOND_KS;
			end
			ST_K3: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_FIRST_KS;
			end
			ST_K4: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WR_SECOND;
				cmd.ks_advance = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_set) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= (kind == KIND_REKEY) ? ST_K1 : ST_G1;
					end
				end
				ST_G1: state_q <= ST_G2;
				ST_G2: state_q <= ST_G3;
				ST_G3: state_q <= ST_G4;
				ST_G4: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_K1: state_q <= ST_K2;
				ST_K2: state_q <= ST_K3;
				ST_K3: state_q <= ST_K4;
				ST_K4: state_q <= status.n_last ? ST_IDLE : ST_K1;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;

endmodule
